### design/fra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_pkg
// Shared widths, command codes and types for the fraction arithmetic block.
// ----------------------------------------------------------------------------
package fra_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int RES_WIDTH     = 33;
   localparam int MAG_WIDTH     = RES_WIDTH - 1;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int EXT_WIDTH     = (PROD_WIDTH > RES_WIDTH) ? PROD_WIDTH : RES_WIDTH;
   localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH);
   localparam int QUEUE_DEPTH   = 2;
   localparam int PTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH   = PTR_WIDTH + 1;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } command_type;

   // one classified item travelling from front to back
   typedef struct packed {
      logic [RES_WIDTH-1:0] num;
      logic [RES_WIDTH-1:0] den;
      logic                 reduce;
   } entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_GCD,
      BACK_DIV
   } back_state_type;

endpackage

### design/fra_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_front
// Accepts items, forms the cross products, builds numerator and denominator
// and marks whether the item must be reduced.
// ----------------------------------------------------------------------------
module fra_front import fra_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      command,
   input  logic signed [OPERAND_WIDTH-1:0] a_num,
   input  logic signed [OPERAND_WIDTH-1:0] a_den,
   input  logic signed [OPERAND_WIDTH-1:0] b_num,
   input  logic signed [OPERAND_WIDTH-1:0] b_den,
   input  logic                            reduce_enable,
   output logic                            push,
   output entry_type                       entry,
   input  logic                            full
);

   function automatic logic [RES_WIDTH-1:0] fit_res(input logic signed [PROD_WIDTH-1:0] p);
      logic signed [EXT_WIDTH-1:0] e;
      e = EXT_WIDTH'(p);
      return e[RES_WIDTH-1:0];
   endfunction

   logic                            s1_valid_ff, s1_valid_in;
   command_type                     cmd_ff;
   logic [RES_WIDTH-1:0]            p0_ff, p1_ff, p2_ff;
   logic                            load;
   logic signed [OPERAND_WIDTH-1:0] sel;
   logic signed [PROD_WIDTH-1:0]    prod0, prod1, prod2;
   logic [RES_WIDTH-1:0]            num, den;
   logic                            num_pos, den_pos;

   assign busy        = s1_valid_ff & full;
   assign load        = start & ~busy;
   assign s1_valid_in = load | (s1_valid_ff & full);

   // multiply uses b_num in the first product, all others b_den
   assign sel   = (command_type'(command) == CMD_MUL) ? b_num : b_den;
   assign prod0 = a_num * sel;
   assign prod1 = b_num * a_den;
   assign prod2 = a_den * b_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= command_type'(command);
         p0_ff  <= fit_res(prod0);
         p1_ff  <= fit_res(prod1);
         p2_ff  <= fit_res(prod2);
      end
   end

   always_comb begin
      case (cmd_ff)
         CMD_ADD: num = p0_ff + p1_ff;
         CMD_SUB: num = p0_ff - p1_ff;
         default: num = p0_ff;
      endcase
      den     = (cmd_ff == CMD_DIV) ? p1_ff : p2_ff;
      num_pos = ~num[RES_WIDTH-1] & (num != '0);
      den_pos = ~den[RES_WIDTH-1] & (den != '0);
   end

   assign push         = s1_valid_ff & ~full;
   assign entry.num    = num;
   assign entry.den    = den;
   assign entry.reduce = reduce_enable & num_pos & den_pos;

endmodule

### design/fra_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module fra_queue import fra_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign full  = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/fra_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_back
// Takes classified items, finds the gcd by the binary method, divides both
// terms by it with two restoring dividers side by side and issues the result.
// ----------------------------------------------------------------------------
module fra_back import fra_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  entry_type            head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [RES_WIDTH-1:0] rsp_res_num,
   output logic [RES_WIDTH-1:0] rsp_res_den
);

   back_state_type         state_ff, state_in;
   logic [MAG_WIDTH-1:0]   x_ff, x_in, y_ff, y_in;
   logic [SHIFT_WIDTH-1:0] k_ff, k_in;
   logic [MAG_WIDTH-1:0]   g_ff, g_in, g;
   logic [MAG_WIDTH-1:0]   qn_ff, qn_in, qd_ff, qd_in;
   logic [MAG_WIDTH-1:0]   rn_ff, rn_in, rd_ff, rd_in;
   logic [SHIFT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RES_WIDTH-1:0]   rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic [MAG_WIDTH:0]     shn, shd;
   logic                   bitn, bitd;

   assign g = (x_ff | y_ff) << k_ff;

   // one restoring step for each term
   always_comb begin
      shn  = {rn_ff, qn_ff[MAG_WIDTH-1]};
      shd  = {rd_ff, qd_ff[MAG_WIDTH-1]};
      bitn = (shn >= {1'b0, g_ff});
      bitd = (shd >= {1'b0, g_ff});
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      pop          = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (!head.reduce) begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = head.num;
                  rsp_den_in   = head.den;
               end else begin
                  x_in     = head.num[MAG_WIDTH-1:0];
                  y_in     = head.den[MAG_WIDTH-1:0];
                  qn_in    = head.num[MAG_WIDTH-1:0];
                  qd_in    = head.den[MAG_WIDTH-1:0];
                  k_in     = '0;
                  state_in = BACK_GCD;
               end
            end
         end
         BACK_GCD: begin
            if (x_ff == '0 || y_ff == '0) begin
               if (g == MAG_WIDTH'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = {1'b0, qn_ff};
                  rsp_den_in   = {1'b0, qd_ff};
                  state_in     = BACK_IDLE;
               end else begin
                  g_in     = g;
                  rn_in    = '0;
                  rd_in    = '0;
                  cnt_in   = '0;
                  state_in = BACK_DIV;
               end
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         BACK_DIV: begin
            rn_in  = bitn ? MAG_WIDTH'(shn - {1'b0, g_ff}) : shn[MAG_WIDTH-1:0];
            rd_in  = bitd ? MAG_WIDTH'(shd - {1'b0, g_ff}) : shd[MAG_WIDTH-1:0];
            qn_in  = {qn_ff[MAG_WIDTH-2:0], bitn};
            qd_in  = {qd_ff[MAG_WIDTH-2:0], bitd};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SHIFT_WIDTH'(MAG_WIDTH - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = {1'b0, qn_in};
               rsp_den_in   = {1'b0, qd_in};
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      cnt_ff     <= cnt_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;

endmodule

### design/fraction_arithmetic_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce
// Adds, subtracts, multiplies or divides two signed fractions and optionally
// reduces the result by the greatest common divisor.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  req      start / busy           req_command, req_a_num .. req_b_den
//  rsp      rsp_valid (strobe)     rsp_res_num, rsp_res_den
//  csr      csr_valid / csr_ready  csr_reduce_enable
//
//  An unreduced item passes the front register, the queue and the response
//  register. A reduced item adds the binary gcd loop (one step a cycle) and,
//  unless the gcd is 1, the two restoring dividers over all 32 quotient bits.
//  The front takes a new item each cycle until the two-entry queue is full;
//  busy then holds it off. Reset is synchronous and clears the queue, the
//  front and back control and reduce_enable. Results cannot be stalled.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reduce import fra_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_command,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                            rsp_valid,
   output logic signed [RES_WIDTH-1:0]     rsp_res_num,
   output logic signed [RES_WIDTH-1:0]     rsp_res_den,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_reduce_enable
);

   logic      reduce_enable_ff;
   logic      push, full, pop, empty;
   entry_type push_entry, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reduce_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         reduce_enable_ff <= csr_reduce_enable;
      end
   end

   fra_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .command       (req_command),
      .a_num         (req_a_num),
      .a_den         (req_a_den),
      .b_num         (req_b_num),
      .b_den         (req_b_den),
      .reduce_enable (reduce_enable_ff),
      .push          (push),
      .entry         (push_entry),
      .full          (full)
   );

   fra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   fra_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den)
   );

endmodule
